@@ design/spm_pkg.sv @@
// Shared types, constants and CRC functions of the sensor polling master.
`default_nettype none

package spm_pkg;

    localparam int MAX_SENSORS = 8;
    localparam int SLOT_W      = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    // Frame bytes
    localparam logic [7:0] HDR_ANSWER  = 8'h3E;
    localparam logic [7:0] HDR_REQUEST = 8'h31;
    localparam logic [7:0] FUNC_READ   = 8'h06;
    localparam logic [7:0] CRC_POLY    = 8'h8C;

    // Result kinds
    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_READING = 2'd1;
    localparam logic [1:0] KIND_CLEARED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_ADDRS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_PERIOD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT     = 3'd4;

    // Everything that one service call produces, serialised later.
    typedef struct packed {
        logic              has_read;
        logic [SLOT_W-1:0] read_slot;
        logic [7:0]        temp;
        logic [15:0]       level;
        logic [15:0]       freq;
        logic              has_req;
        logic              has_clr;
        logic [SLOT_W-1:0] act_slot;
        logic [7:0]        req_addr;
    } t_bundle;

    // One byte of the reflected Dallas CRC-8.
    function automatic logic [7:0] crc8_step(input logic [7:0] data, input logic [7:0] crc);
        logic [7:0] c;
        c = data ^ crc;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // CRC of a request frame; the first step folds to a constant.
    function automatic logic [7:0] request_crc(input logic [7:0] addr);
        return crc8_step(FUNC_READ, crc8_step(addr, crc8_step(HDR_REQUEST, 8'h00)));
    endfunction

endpackage

`default_nettype wire

@@ design/sensor_poll_master_crc8.sv @@
// Top level of the polling bus master for up to eight level sensors.
//
//   channel   direction  handshake             payload
//   input     in         i_valid / o_ready     i_action, i_rx_byte
//   result    out        o_valid / i_ready     o_kind .. o_last
//   config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// Each service request is parsed and scheduled in the cycle it is accepted, so
// one request per cycle is taken while the two-entry result queue has room.
// A request gives up to five results, emitted one per cycle from the queue head while i_ready is high.
// Synchronous active-low reset clears control state and loads register defaults.
// A stalled result side holds the head; input stalls only when both entries are full.
`default_nettype none

module sensor_poll_master_crc8 (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [spm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [spm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_action,
    input  wire logic [7:0]                       i_rx_byte,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [1:0]                            o_kind,
    output logic [7:0]                            o_tx_byte,
    output logic [spm_pkg::SLOT_W-1:0]            o_sensor_slot,
    output logic signed [7:0]                     o_temperature,
    output logic [15:0]                           o_level,
    output logic [15:0]                           o_frequency,
    output logic                                  o_last
);
    import spm_pkg::*;

    logic    take, push, space;
    t_bundle bundle;
    logic [7:0] temp_bits;

    assign o_ready = space;
    assign take    = i_valid && space;

    spm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_take     (take),
        .i_action   (i_action),
        .i_rx_byte  (i_rx_byte),
        .o_push     (push),
        .o_bundle   (bundle)
    );

    spm_outq u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_bundle      (bundle),
        .o_space       (space),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_tx_byte     (o_tx_byte),
        .o_sensor_slot (o_sensor_slot),
        .o_temperature (temp_bits),
        .o_level       (o_level),
        .o_frequency   (o_frequency),
        .o_last        (o_last)
    );

    assign o_temperature = signed'(temp_bits);

endmodule

`default_nettype wire

@@ design/spm_core.sv @@
// Answer parser, polling scheduler and configuration registers.
`default_nettype none

module spm_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [spm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [spm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_take,
    input  wire logic                             i_action,
    input  wire logic [7:0]                       i_rx_byte,
    output logic                                  o_push,
    output spm_pkg::t_bundle                      o_bundle
);
    import spm_pkg::*;

    typedef enum logic [8:0] {
        PS_IDLE   = 9'b000000001,
        PS_ADDR   = 9'b000000010,
        PS_FUNC   = 9'b000000100,
        PS_TEMP   = 9'b000001000,
        PS_LVL_LO = 9'b000010000,
        PS_LVL_HI = 9'b000100000,
        PS_FRQ_LO = 9'b001000000,
        PS_FRQ_HI = 9'b010000000,
        PS_CRC    = 9'b100000000
    } t_parse;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s,
                                                    input logic [3:0] cnt);
        logic [3:0]        lim;
        logic [SLOT_W-1:0] nx;
        lim = (cnt > 4'(MAX_SENSORS)) ? 4'(MAX_SENSORS) : cnt;
        nx  = s + 1'b1;
        return ({1'b0, nx} >= lim) ? '0 : nx;
    endfunction

    // Configuration
    logic [3:0]  r_count;
    logic [63:0] r_addrs;
    logic [15:0] r_period;
    logic [15:0] r_timeout;
    logic [7:0]  r_limit;

    // State
    logic [15:0]       r_tick,  n_tick;
    logic              r_wait,  n_wait;
    logic [15:0]       r_cd,    n_cd;
    logic [SLOT_W-1:0] r_slot,  n_slot;
    t_parse            r_stage, n_stage;
    logic [7:0]        r_crc,   n_crc;
    logic [7:0]        r_temp,  n_temp;
    logic [15:0]       r_level, n_level;
    logic [7:0]        r_frq_lo, n_frq_lo;
    logic [7:0]        r_miss [MAX_SENSORS];
    logic [7:0]        n_miss [MAX_SENSORS];

    logic              rd_ok, req, clr;
    logic              wait1;
    logic [15:0]       cd1, tick_inc;
    logic [SLOT_W-1:0] slot1;
    logic [7:0]        crc_base, miss_inc;
    logic [7:0]        cur_addr;

    assign cur_addr = r_addrs[{r_slot, 3'b000} +: 8];

    always_comb begin
        n_tick   = r_tick;
        n_wait   = r_wait;
        n_cd     = r_cd;
        n_slot   = r_slot;
        n_stage  = r_stage;
        n_crc    = r_crc;
        n_temp   = r_temp;
        n_level  = r_level;
        n_frq_lo = r_frq_lo;
        n_miss   = r_miss;
        rd_ok    = 1'b0;
        req      = 1'b0;
        clr      = 1'b0;
        crc_base = r_crc;
        miss_inc = r_miss[r_slot] + 8'd1;
        tick_inc = r_tick + 16'd1;

        if (i_take && i_action) begin
            case (r_stage)
                PS_IDLE: begin
                    if (i_rx_byte == HDR_ANSWER) begin
                        crc_base = 8'h00;
                        n_stage  = PS_ADDR;
                    end
                end
                PS_ADDR:   n_stage = (i_rx_byte == cur_addr) ? PS_FUNC : PS_IDLE;
                PS_FUNC:   n_stage = (i_rx_byte == FUNC_READ) ? PS_TEMP : PS_IDLE;
                PS_TEMP: begin
                    n_temp  = i_rx_byte;
                    n_stage = PS_LVL_LO;
                end
                PS_LVL_LO: begin
                    n_level = {8'h00, i_rx_byte};
                    n_stage = PS_LVL_HI;
                end
                PS_LVL_HI: begin
                    n_level = {i_rx_byte, r_level[7:0]};
                    n_stage = PS_FRQ_LO;
                end
                PS_FRQ_LO: begin
                    n_frq_lo = i_rx_byte;
                    n_stage  = PS_FRQ_HI;
                end
                PS_FRQ_HI: begin
                    n_level = r_level;
                    n_stage = PS_CRC;
                    // The high byte of the frequency is captured in its own
                    // register below until the check byte arrives.
                end
                PS_CRC: begin
                    rd_ok   = (r_crc == i_rx_byte);
                    n_stage = PS_IDLE;
                end
                default:   n_stage = PS_IDLE;
            endcase
            n_crc = crc8_step(i_rx_byte, crc_base);
        end

        wait1 = rd_ok ? 1'b0 : r_wait;
        cd1   = rd_ok ? 16'd0 : r_cd;
        slot1 = rd_ok ? next_slot(r_slot, r_count) : r_slot;
        if (rd_ok) begin
            n_miss[r_slot] = 8'd0;
        end
        n_wait = wait1;
        n_cd   = cd1;
        n_slot = slot1;

        if (i_take) begin
            if (tick_inc >= r_period) begin
                n_tick = 16'd0;
                if (!wait1) begin
                    req    = 1'b1;
                    n_wait = 1'b1;
                    n_cd   = r_timeout;
                end else if (cd1 > r_period) begin
                    n_cd = cd1 - r_period;
                end else begin
                    // A miss never follows a good answer in the same call,
                    // so slot1 equals the registered slot here.
                    n_wait = 1'b0;
                    if (miss_inc >= r_limit) begin
                        clr            = 1'b1;
                        n_miss[slot1]  = 8'd0;
                    end else begin
                        n_miss[slot1]  = miss_inc;
                    end
                    n_slot = next_slot(slot1, r_count);
                end
            end else begin
                n_tick = tick_inc;
            end
        end
    end

    // High byte of the frequency waits here for the check byte.
    logic [7:0] r_frq_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 4'd1;
            r_addrs   <= '0;
            r_period  <= 16'd1;
            r_timeout <= 16'd100;
            r_limit   <= 8'd3;
            r_tick    <= '0;
            r_wait    <= 1'b0;
            r_cd      <= '0;
            r_slot    <= '0;
            r_stage   <= PS_IDLE;
            r_crc     <= '0;
            for (int i = 0; i < MAX_SENSORS; i++) begin
                r_miss[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SENSOR_COUNT:   r_count   <= i_cfg_data[3:0];
                    CFG_SENSOR_ADDRS:   r_addrs   <= i_cfg_data[63:0];
                    CFG_SERVICE_PERIOD: r_period  <= i_cfg_data[15:0];
                    CFG_ANSWER_TIMEOUT: r_timeout <= i_cfg_data[15:0];
                    CFG_MISS_LIMIT:     r_limit   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            r_tick  <= n_tick;
            r_wait  <= n_wait;
            r_cd    <= n_cd;
            r_slot  <= n_slot;
            r_stage <= n_stage;
            r_crc   <= n_crc;
            r_miss  <= n_miss;
        end
    end

    always_ff @(posedge i_clk) begin
        r_temp   <= n_temp;
        r_level  <= n_level;
        r_frq_lo <= n_frq_lo;
        if (i_take && i_action && (r_stage == PS_FRQ_HI)) begin
            r_frq_hi <= i_rx_byte;
        end
    end

    always_comb begin
        o_bundle.has_read  = rd_ok;
        o_bundle.read_slot = r_slot;
        o_bundle.temp      = r_temp;
        o_bundle.level     = r_level;
        o_bundle.freq      = {r_frq_hi, r_frq_lo};
        o_bundle.has_req   = req;
        o_bundle.has_clr   = clr;
        o_bundle.act_slot  = slot1;
        o_bundle.req_addr  = r_addrs[{slot1, 3'b000} +: 8];
    end

    assign o_push = rd_ok | req | clr;

endmodule

`default_nettype wire

@@ design/spm_outq.sv @@
// Two-entry queue of per-call result groups and the serialiser that emits them.
`default_nettype none

module spm_outq (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire spm_pkg::t_bundle           i_bundle,
    output logic                            o_space,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [1:0]                      o_kind,
    output logic [7:0]                      o_tx_byte,
    output logic [spm_pkg::SLOT_W-1:0]      o_sensor_slot,
    output logic [7:0]                      o_temperature,
    output logic [15:0]                     o_level,
    output logic [15:0]                     o_frequency,
    output logic                            o_last
);
    import spm_pkg::*;

    t_bundle    r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt, n_cnt;
    logic       r_read_done, n_read_done;
    logic [1:0] r_byte, n_byte;

    t_bundle head;
    logic    is_read, take, pop;

    assign head    = r_q[r_rd];
    assign o_valid = (r_cnt != 2'd0);
    assign o_space = (r_cnt != 2'd2);
    assign is_read = head.has_read && !r_read_done;

    always_comb begin
        o_kind        = KIND_CLEARED;
        o_tx_byte     = 8'h00;
        o_sensor_slot = head.act_slot;
        o_temperature = 8'h00;
        o_level       = 16'h0000;
        o_frequency   = 16'h0000;
        o_last        = 1'b1;
        if (is_read) begin
            o_kind        = KIND_READING;
            o_sensor_slot = head.read_slot;
            o_temperature = head.temp;
            o_level       = head.level;
            o_frequency   = head.freq;
            o_last        = !(head.has_req || head.has_clr);
        end else if (head.has_req) begin
            o_kind = KIND_TX;
            o_last = (r_byte == 2'd3);
            case (r_byte)
                2'd0:    o_tx_byte = HDR_REQUEST;
                2'd1:    o_tx_byte = head.req_addr;
                2'd2:    o_tx_byte = FUNC_READ;
                default: o_tx_byte = request_crc(head.req_addr);
            endcase
        end
    end

    assign take = o_valid && i_ready;
    assign pop  = take && o_last;

    always_comb begin
        n_read_done = r_read_done;
        n_byte      = r_byte;
        if (pop) begin
            n_read_done = 1'b0;
            n_byte      = 2'd0;
        end else if (take) begin
            if (is_read) begin
                n_read_done = 1'b1;
            end else begin
                n_byte = r_byte + 2'd1;
            end
        end
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd        <= 1'b0;
            r_wr        <= 1'b0;
            r_cnt       <= 2'd0;
            r_read_done <= 1'b0;
            r_byte      <= 2'd0;
        end else begin
            r_cnt       <= n_cnt;
            r_read_done <= n_read_done;
            r_byte      <= n_byte;
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_bundle;
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the sensor polling bus master, with its own behavioural predictor.
`timescale 1ns / 100ps

module tb_top;
    import spm_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 250;
    localparam int PRINT_CAP     = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_BYTE = 1'b1;

    // Answer parser stages
    localparam logic [3:0] STG_IDLE   = 4'd0;
    localparam logic [3:0] STG_ADDR   = 4'd1;
    localparam logic [3:0] STG_FUNC   = 4'd2;
    localparam logic [3:0] STG_TEMP   = 4'd3;
    localparam logic [3:0] STG_LVL_LO = 4'd4;
    localparam logic [3:0] STG_LVL_HI = 4'd5;
    localparam logic [3:0] STG_FRQ_LO = 4'd6;
    localparam logic [3:0] STG_FRQ_HI = 4'd7;
    localparam logic [3:0] STG_CRC    = 4'd8;

    typedef enum int {ANS_GOOD, ANS_BAD_CRC, ANS_BAD_ADDR, ANS_BAD_FUNC, ANS_CUT} t_answer_fault;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [2:0]  slot;
        logic [7:0]  temperature;
        logic [15:0] level;
        logic [15:0] frequency;
        logic        last;
    } t_poll_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_valid;
    logic                    o_ready;
    logic                    i_action;
    logic [7:0]              i_rx_byte;
    logic                    o_valid;
    logic                    i_ready;
    logic [1:0]              o_kind;
    logic [7:0]              o_tx_byte;
    logic [SLOT_W-1:0]       o_sensor_slot;
    logic signed [7:0]       o_temperature;
    logic [15:0]             o_level;
    logic [15:0]             o_frequency;
    logic                    o_last;

    // Predicted register contents
    logic [3:0]  set_count;
    logic [63:0] set_addrs;
    logic [15:0] set_period;
    logic [15:0] set_timeout;
    logic [7:0]  set_limit;

    // Predicted block state
    logic [15:0] mdl_tick;
    logic        mdl_waiting;
    logic [15:0] mdl_countdown;
    logic [2:0]  mdl_slot;
    logic [3:0]  mdl_stage;
    logic [7:0]  mdl_crc;
    logic [7:0]  mdl_temp;
    logic [15:0] mdl_level;
    logic [15:0] mdl_freq;
    logic [7:0]  mdl_miss [8];

    t_poll_result expected_results[$];

    int  error_count      = 0;
    int  cycle_count      = 0;
    int  calls_sent       = 0;
    int  registers_written = 0;
    int  results_checked  = 0;
    int  readings_seen    = 0;
    int  clears_seen      = 0;
    int  requests_seen    = 0;
    int  hold_request     = 0;
    bit  sender_steady    = 0;
    bit  results_steady   = 0;

    sensor_poll_master_crc8 DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_tx_byte     (o_tx_byte),
        .o_sensor_slot (o_sensor_slot),
        .o_temperature (o_temperature),
        .o_level       (o_level),
        .o_frequency   (o_frequency),
        .o_last        (o_last)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run stopped by the watchdog after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Bit-serial form of the reflected Dallas CRC-8, least significant bit first.
    function automatic logic [7:0] dallas_crc(input logic [7:0] data, input logic [7:0] crc);
        logic [7:0] acc;
        logic       fb;
        acc = crc;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ data[i];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic logic [7:0] slot_address(input logic [2:0] slot);
        return set_addrs[slot * 8 +: 8];
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [63:0] pad_junk(input logic [15:0] low);
        return {32'($urandom), 16'($urandom), low};
    endfunction

    task automatic reset_model();
        set_count     = 4'd1;
        set_addrs     = '0;
        set_period    = 16'd1;
        set_timeout   = 16'd100;
        set_limit     = 8'd3;
        mdl_tick      = '0;
        mdl_waiting   = 1'b0;
        mdl_countdown = '0;
        mdl_slot      = '0;
        mdl_stage     = STG_IDLE;
        mdl_crc       = '0;
        mdl_temp      = '0;
        mdl_level     = '0;
        mdl_freq      = '0;
        foreach (mdl_miss[i]) mdl_miss[i] = '0;
    endtask

    task automatic advance_slot_model();
        logic [3:0] n;
        n = (set_count > 4'(MAX_SENSORS)) ? 4'(MAX_SENSORS) : set_count;
        mdl_slot = mdl_slot + 3'd1;
        if ({1'b0, mdl_slot} >= n) begin
            mdl_slot = '0;
        end
    endtask

    // Works out the results of one service call and queues them in order.
    task automatic predict_service_call(input logic act, input logic [7:0] data);
        t_poll_result found[$];
        t_poll_result r;
        logic [7:0]   req [4];
        logic [7:0]   acc;
        logic [3:0]   next_stage;
        if (act == ACT_BYTE) begin
            next_stage = STG_IDLE;
            case (mdl_stage)
                STG_IDLE: begin
                    if (data == HDR_ANSWER) begin
                        mdl_crc    = 8'h00;
                        next_stage = STG_ADDR;
                    end
                end
                STG_ADDR: next_stage = (data == slot_address(mdl_slot)) ? STG_FUNC : STG_IDLE;
                STG_FUNC: next_stage = (data == FUNC_READ) ? STG_TEMP : STG_IDLE;
                STG_TEMP: begin
                    mdl_temp   = data;
                    next_stage = STG_LVL_LO;
                end
                STG_LVL_LO: begin
                    mdl_level  = {8'h00, data};
                    next_stage = STG_LVL_HI;
                end
                STG_LVL_HI: begin
                    mdl_level[15:8] = data;
                    next_stage      = STG_FRQ_LO;
                end
                STG_FRQ_LO: begin
                    mdl_freq   = {8'h00, data};
                    next_stage = STG_FRQ_HI;
                end
                STG_FRQ_HI: begin
                    mdl_freq[15:8] = data;
                    next_stage     = STG_CRC;
                end
                STG_CRC: begin
                    if (data == mdl_crc) begin
                        r             = '0;
                        r.kind        = KIND_READING;
                        r.slot        = mdl_slot;
                        r.temperature = mdl_temp;
                        r.level       = mdl_level;
                        r.frequency   = mdl_freq;
                        found.push_back(r);
                        mdl_miss[mdl_slot] = '0;
                        mdl_waiting        = 1'b0;
                        mdl_countdown      = '0;
                        advance_slot_model();
                    end
                end
                default: next_stage = STG_IDLE;
            endcase
            mdl_stage = next_stage;
            // Every byte folds into the CRC; a header restarts it first.
            mdl_crc = dallas_crc(data, mdl_crc);
        end

        mdl_tick = mdl_tick + 16'd1;
        if (mdl_tick >= set_period) begin
            mdl_tick = '0;
            if (!mdl_waiting) begin
                req[0] = HDR_REQUEST;
                req[1] = slot_address(mdl_slot);
                req[2] = FUNC_READ;
                acc    = 8'h00;
                for (int k = 0; k < 3; k++) acc = dallas_crc(req[k], acc);
                req[3] = acc;
                for (int k = 0; k < 4; k++) begin
                    r         = '0;
                    r.kind    = KIND_TX;
                    r.tx_byte = req[k];
                    r.slot    = mdl_slot;
                    found.push_back(r);
                end
                mdl_waiting   = 1'b1;
                mdl_countdown = set_timeout;
            end else if (mdl_countdown > set_period) begin
                mdl_countdown = mdl_countdown - set_period;
            end else begin
                mdl_waiting        = 1'b0;
                mdl_miss[mdl_slot] = mdl_miss[mdl_slot] + 8'd1;
                if (mdl_miss[mdl_slot] >= set_limit) begin
                    mdl_miss[mdl_slot] = '0;
                    r      = '0;
                    r.kind = KIND_CLEARED;
                    r.slot = mdl_slot;
                    found.push_back(r);
                end
                advance_slot_model();
            end
        end

        if (found.size() > 0) begin
            found[found.size() - 1].last = 1'b1;
        end
        foreach (found[i]) expected_results.push_back(found[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_CAP) begin
            $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
    endtask

    task automatic send_service_call(input logic act, input logic [7:0] data);
        int gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_rx_byte <= data;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_service_call(act, data);
        calls_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_service_call(ACT_TICK, 8'($urandom));
    endtask

    // Sends an answer frame for the slot being polled, damaged as asked.
    task automatic send_answer(input t_answer_fault fault, input logic [7:0] temp,
                               input logic [15:0] level, input logic [15:0] freq);
        logic [7:0] frame [9];
        logic [7:0] acc;
        int         n;
        frame[0] = HDR_ANSWER;
        frame[1] = slot_address(mdl_slot);
        frame[2] = FUNC_READ;
        frame[3] = temp;
        frame[4] = level[7:0];
        frame[5] = level[15:8];
        frame[6] = freq[7:0];
        frame[7] = freq[15:8];
        acc = 8'h00;
        for (int k = 0; k < 8; k++) acc = dallas_crc(frame[k], acc);
        frame[8] = acc;
        n = 9;
        case (fault)
            ANS_BAD_CRC:  frame[8] = acc ^ 8'(1 << $urandom_range(0, 7));
            ANS_BAD_ADDR: begin
                frame[1] = frame[1] ^ 8'(1 << $urandom_range(0, 7));
                n = 2;
            end
            ANS_BAD_FUNC: begin
                frame[2] = frame[2] ^ 8'(1 << $urandom_range(0, 7));
                n = 3;
            end
            ANS_CUT:      n = $urandom_range(1, 8);
            default: ;
        endcase
        for (int k = 0; k < n; k++) send_service_call(ACT_BYTE, frame[k]);
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_SENSOR_COUNT:   set_count   = value[3:0];
            CFG_SENSOR_ADDRS:   set_addrs   = value;
            CFG_SERVICE_PERIOD: set_period  = value[15:0];
            CFG_ANSWER_TIMEOUT: set_timeout = value[15:0];
            CFG_MISS_LIMIT:     set_limit   = value[7:0];
            default: ;
        endcase
        registers_written++;
    endtask

    task automatic load_settings(input logic [3:0] count, input logic [63:0] addrs,
                                 input logic [15:0] period, input logic [15:0] timeout,
                                 input logic [7:0] limit);
        write_register(CFG_SENSOR_COUNT, pad_junk({12'($urandom), count}));
        write_register(CFG_SENSOR_ADDRS, addrs);
        write_register(CFG_SERVICE_PERIOD, pad_junk(period));
        write_register(CFG_ANSWER_TIMEOUT, pad_junk(timeout));
        write_register(CFG_MISS_LIMIT, pad_junk({8'($urandom), limit}));
    endtask

    // Reset values: one slot at address zero, a service period that ends on every call.
    task automatic test_default_polling();
        send_ticks(1);
        // A good answer clears the wait, so the same call also sends the next request.
        send_answer(ANS_GOOD, 8'h80, 16'hFFFF, 16'h0000);
        wait_results_drained();
    endtask

    task automatic test_answer_faults();
        send_answer(ANS_BAD_CRC, 8'h12, 16'h3456, 16'h789A);
        send_answer(ANS_BAD_ADDR, 8'h00, 16'h0000, 16'h0000);
        send_answer(ANS_BAD_FUNC, 8'h00, 16'h0000, 16'h0000);
        // Stray bytes in the idle stage must not spoil the CRC of the next frame.
        send_service_call(ACT_BYTE, 8'h55);
        send_service_call(ACT_BYTE, 8'hAA);
        send_answer(ANS_GOOD, 8'h7F, 16'h0000, 16'hFFFF);
        wait_results_drained();
    endtask

    task automatic test_register_extremes();
        // Zero count, period, timeout and limit behave as one, one, expire-at-once and one.
        load_settings(4'd0, 64'({$urandom, $urandom}), 16'd0, 16'd0, 8'd0);
        send_ticks(6);
        wait_results_drained();
        load_settings(4'd15, 64'({$urandom, $urandom}), 16'd1, 16'd1, 8'd1);
        send_ticks(20);
        wait_results_drained();
        load_settings(4'd8, 64'({$urandom, $urandom}), 16'd1, 16'hFFFF, 8'hFF);
        send_ticks(3);
        send_answer(ANS_GOOD, 8'($urandom), 16'($urandom), 16'($urandom));
        wait_results_drained();
        write_register(CFG_SERVICE_PERIOD, pad_junk(16'hFFFF));
        send_ticks(3);
        send_answer(ANS_GOOD, 8'($urandom), 16'($urandom), 16'($urandom));
        wait_results_drained();
        write_register(CFG_UNUSED, 64'({$urandom, $urandom}));
    endtask

    task automatic test_lowered_settings();
        load_settings(4'd8, 64'({$urandom, $urandom}), 16'd1, 16'd0, 8'd200);
        send_ticks(10);
        wait_results_drained();
        // The polled slot now lies beyond the new count and must wrap to zero.
        write_register(CFG_SENSOR_COUNT, pad_junk(16'd2));
        send_ticks(4);
        wait_results_drained();
        write_register(CFG_SENSOR_COUNT, pad_junk(16'd1));
        write_register(CFG_MISS_LIMIT, pad_junk(16'd3));
        send_ticks(4);
        wait_results_drained();
        write_register(CFG_MISS_LIMIT, pad_junk(16'd1));
        send_ticks(2);
        wait_results_drained();
        write_register(CFG_SERVICE_PERIOD, pad_junk(16'd40));
        send_ticks(20);
        wait_results_drained();
        write_register(CFG_SERVICE_PERIOD, pad_junk(16'd5));
        send_ticks(3);
        wait_results_drained();
    endtask

    task automatic test_result_backpressure();
        load_settings(4'd4, 64'({$urandom, $urandom}), 16'd1, 16'd0, 8'd1);
        sender_steady = 1;
        hold_request  = HOLD_CYCLES;
        send_ticks(40);
        send_answer(ANS_GOOD, 8'($urandom), 16'($urandom), 16'($urandom));
        send_ticks(20);
        sender_steady = 0;
        wait_results_drained();
    endtask

    task automatic test_random_traffic(input int calls);
        int start;
        int roll;
        logic [7:0] noise;
        start = calls_sent;
        while (calls_sent - start < calls) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                // Flush a half-parsed frame so that most new frames start clean.
                while (mdl_stage != STG_IDLE) begin
                    noise = 8'($urandom);
                    send_service_call(ACT_BYTE, (noise == HDR_ANSWER) ? ~noise : noise);
                end
            end
            if (roll < 60) begin
                send_answer(ANS_GOOD, 8'($urandom), 16'($urandom), 16'($urandom));
            end else if (roll < 68) begin
                send_answer(ANS_BAD_CRC, 8'($urandom), 16'($urandom), 16'($urandom));
            end else if (roll < 72) begin
                send_answer(ANS_BAD_ADDR, 8'($urandom), 16'($urandom), 16'($urandom));
            end else if (roll < 76) begin
                send_answer(ANS_BAD_FUNC, 8'($urandom), 16'($urandom), 16'($urandom));
            end else if (roll < 80) begin
                send_answer(ANS_CUT, 8'($urandom), 16'($urandom), 16'($urandom));
            end else if (roll < 92) begin
                send_ticks($urandom_range(1, 6));
            end else begin
                send_service_call(ACT_BYTE, 8'($urandom));
            end
        end
    endtask

    task automatic test_random_settings();
        for (int round = 0; round < 4; round++) begin
            wait_results_drained();
            load_settings(4'($urandom_range(0, 15)), 64'({$urandom, $urandom}),
                          16'($urandom_range(0, 3)), 16'($urandom_range(0, 30)),
                          8'($urandom_range(0, 4)));
            sender_steady  = (round == 2);
            results_steady = (round == 2);
            test_random_traffic(15);
            // Sender waits here until every outstanding result has been taken.
            if (round == 1) begin
                wait_results_drained();
            end
            test_random_traffic(10);
        end
        sender_steady  = 0;
        results_steady = 0;
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial begin : result_sink
        int gap;
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                i_ready <= 1'b0;
                repeat (hold_request) @(posedge i_clk);
                hold_request = 0;
            end else begin
                gap = results_steady ? 0 : pick_gap();
                if (gap == 0) begin
                    i_ready <= 1'b1;
                    @(posedge i_clk);
                end else begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // Sample at the edge, compare once this time step's predictions are queued.
    always @(posedge i_clk) begin : result_check
        t_poll_result got;
        t_poll_result want;
        logic         taken;
        taken             = i_rst_n && o_valid && i_ready;
        got.kind          = o_kind;
        got.tx_byte       = o_tx_byte;
        got.slot          = o_sensor_slot;
        got.temperature   = $unsigned(o_temperature);
        got.level         = o_level;
        got.frequency     = o_frequency;
        got.last          = o_last;
        #1;
        if (taken) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected, kind", 64'(got.kind), '0);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.kind == KIND_READING) readings_seen++;
                if (want.kind == KIND_CLEARED) clears_seen++;
                if (want.kind == KIND_TX) requests_seen++;
                if (got.kind !== want.kind)
                    report_mismatch("kind", 64'(got.kind), 64'(want.kind));
                if (got.tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", 64'(got.tx_byte), 64'(want.tx_byte));
                if (got.slot !== want.slot)
                    report_mismatch("sensor_slot", 64'(got.slot), 64'(want.slot));
                if (got.temperature !== want.temperature)
                    report_mismatch("temperature", 64'(got.temperature),
                                    64'(want.temperature));
                if (got.level !== want.level)
                    report_mismatch("level", 64'(got.level), 64'(want.level));
                if (got.frequency !== want.frequency)
                    report_mismatch("frequency", 64'(got.frequency), 64'(want.frequency));
                if (got.last !== want.last)
                    report_mismatch("last", 64'(got.last), 64'(want.last));
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_SENSOR_COUNT;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_action   <= ACT_TICK;
        i_rx_byte  <= '0;
        reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_polling();
        test_answer_faults();
        test_register_extremes();
        test_lowered_settings();
        test_result_backpressure();
        test_random_settings();
        wait_results_drained();

        if (expected_results.size() != 0) begin
            report_mismatch("results never delivered", 64'(expected_results.size()), '0);
        end
        $display("Covered %0d service calls and %0d register writes in %0d cycles.",
                 calls_sent, registers_written, cycle_count);
        $display("Checked %0d results: %0d readings, %0d slot clears, %0d request bytes.",
                 results_checked, readings_seen, clears_seen, requests_seen);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
